// ===== hdl/nsp_pkg.sv =====
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared types and codes of the nearest segment pick unit.
// ----------------------------------------------------------------------------
package nsp_pkg;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_POST = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   typedef enum logic [2:0] {
      JOB_LEN0 = 3'd0,
      JOB_LEN1 = 3'd1,
      JOB_DOT0 = 3'd2,
      JOB_DOT1 = 3'd3,
      JOB_SCX  = 3'd4,
      JOB_SCY  = 3'd5,
      JOB_DST0 = 3'd6,
      JOB_DST1 = 3'd7
   } job_type;

   localparam logic [1:0] CSR_QUERY_X  = 2'd0;
   localparam logic [1:0] CSR_QUERY_Y  = 2'd1;
   localparam logic [1:0] CSR_RADIUS   = 2'd2;
   localparam logic [1:0] CSR_VISIBLE  = 2'd3;

endpackage

// ===== hdl/nearest_segment_pick_unit.sv =====
// ----------------------------------------------------------------------------
// nearest_segment_pick_unit
// Nearest line segment hit test over a stream of link segments.
// ----------------------------------------------------------------------------
// The req channel carries one segment per item: two endpoints in signed Q24.8,
// a link id and a last mark. The rsp channel carries one item per scan, the id
// of the nearest link strictly inside the pick radius, or zero. The csr port
// sets the query point, the pick radius and the overlay visibility; it is to be
// written only while the block is idle, but the block itself does not enforce this.
// An item is worked on alone. Its arithmetic runs through one shift-and-add
// multiplier that retires one multiplier bit per cycle, and a restoring
// divider that retires one quotient bit per cycle. A segment runs up to eight
// multiply jobs, each followed by one bookkeeping step, and a divide when the
// projection falls inside the segment. A segment whose coordinates are all
// zero is accepted without any job and is not compared. A zero-length segment
// skips the dot product, the divide and the scaling jobs; a projection that
// clamps to the start point skips the divide and the scaling jobs, and one
// that clamps to the end point skips only the divide.
// Reset returns the block to idle with no result pending and a fresh scan.
// When the receiver stalls, a finished result waits in the output register;
// the next item is still accepted and worked on, and only a second result
// waits until the first has been taken.
// ----------------------------------------------------------------------------
module nearest_segment_pick_unit
   import nsp_pkg::*;
#(
   parameter int COORD_WIDTH     = 32,
   parameter int T_FRACTION_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [COORD_WIDTH-1:0] req_seg_ax,
   input  logic signed [COORD_WIDTH-1:0] req_seg_ay,
   input  logic signed [COORD_WIDTH-1:0] req_seg_bx,
   input  logic signed [COORD_WIDTH-1:0] req_seg_by,
   input  logic [31:0]                   req_link_id,
   input  logic                          req_last_link,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [31:0]                   rsp_best_link_id,
   input  logic                          csr_write_enable,
   input  logic [1:0]                    csr_index,
   input  logic [31:0]                   csr_data
);

   localparam int W    = COORD_WIDTH;
   localparam int F    = T_FRACTION_BITS;
   // Magnitude width of every coordinate operand, wide enough for the final offsets.
   localparam int MW   = W + 2;
   localparam int TW   = F + 1;
   localparam int LW   = (MW > TW) ? MW : TW;
   localparam int PW   = 2 * MW + F + 2;
   localparam int CW   = (PW + 1 > 64) ? PW + 1 : 64;
   localparam int CNTW = $clog2(LW + 1);

   function automatic logic [MW-1:0] mag(input logic signed [MW:0] v);
      logic signed [MW:0] n;
      n = v[MW] ? -v : v;
      return n[MW-1:0];
   endfunction

   // Configuration.
   logic [31:0] query_x_ff, query_y_ff;
   logic [30:0] radius_ff;
   logic        visible_ff;

   // Scan state.
   logic [63:0] best_dist_ff;
   logic [31:0] best_id_ff;
   logic        scan_start_ff;

   // Item state.
   state_type          state_ff;
   job_type            job_ff;
   logic               last_ff;
   logic [31:0]        id_ff;
   logic signed [MW:0] abx_ff, aby_ff, apx_ff, apy_ff, sx_ff, sy_ff;
   logic [PW-1:0]      len_ff;

   // Shared multiplier and divider.
   logic [PW-1:0]      mc_ff;
   logic [LW-1:0]      mp_ff;
   logic               neg_ff;
   logic signed [PW:0] acc_ff;
   logic [CNTW-1:0]    cnt_ff;
   logic [PW-1:0]      rem_ff;
   logic [TW-1:0]      t_ff;

   logic                 rsp_valid_ff;
   logic [31:0]          rsp_id_ff;

   logic signed [W-1:0]  qx, qy;
   logic                 accept;
   logic                 empty_seg;
   logic signed [PW:0]   addend;
   logic [PW-1:0]        rem_shift;
   logic                 rem_ge;
   logic [PW-1:0]        rounded;
   logic signed [MW:0]   q_mag;
   logic signed [MW:0]   offset_in;
   logic [CW-1:0]        d2_ext, best_ext;

   assign qx        = W'(query_x_ff);
   assign qy        = W'(query_y_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign empty_seg = (req_seg_ax == '0) && (req_seg_ay == '0) &&
                      (req_seg_bx == '0) && (req_seg_by == '0);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_best_link_id = rsp_id_ff;

   always_comb begin
      addend    = $signed({1'b0, mc_ff});
      if (neg_ff) begin
         addend = -addend;
      end
      rem_shift = {rem_ff[PW-2:0], 1'b0};
      rem_ge    = (rem_shift >= len_ff);
      // Rounded scale t*d / 2^F, ties away from zero on the magnitude.
      rounded   = acc_ff[PW-1:0] + (PW'(1) << (F - 1));
      q_mag     = (MW+1)'(rounded >> F);
      if (job_ff == JOB_SCX) begin
         offset_in = apx_ff - (abx_ff[MW] ? -q_mag : q_mag);
      end else begin
         offset_in = apy_ff - (aby_ff[MW] ? -q_mag : q_mag);
      end
      d2_ext    = CW'(acc_ff[PW-1:0]);
      best_ext  = CW'(best_dist_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff    <= '0;
         query_y_ff    <= '0;
         radius_ff     <= '0;
         visible_ff    <= 1'b0;
         best_dist_ff  <= '0;
         best_id_ff    <= '0;
         scan_start_ff <= 1'b1;
         state_ff      <= ST_IDLE;
         job_ff        <= JOB_LEN0;
         rsp_valid_ff  <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_QUERY_X: query_x_ff <= csr_data;
               CSR_QUERY_Y: query_y_ff <= csr_data;
               CSR_RADIUS:  radius_ff  <= csr_data[30:0];
               CSR_VISIBLE: visible_ff <= csr_data[0];
               default: ;
            endcase
         end

         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  // The radius in force at the first item of a scan sets the bar.
                  if (scan_start_ff) begin
                     best_dist_ff  <= 64'(radius_ff) * 64'(radius_ff);
                     best_id_ff    <= '0;
                     scan_start_ff <= 1'b0;
                  end
                  last_ff <= req_last_link;
                  id_ff   <= req_link_id;
                  abx_ff  <= (MW+1)'(req_seg_bx) - (MW+1)'(req_seg_ax);
                  aby_ff  <= (MW+1)'(req_seg_by) - (MW+1)'(req_seg_ay);
                  apx_ff  <= (MW+1)'(qx) - (MW+1)'(req_seg_ax);
                  apy_ff  <= (MW+1)'(qy) - (MW+1)'(req_seg_ay);
                  if (empty_seg) begin
                     state_ff <= req_last_link ? ST_OUT : ST_IDLE;
                  end else begin
                     mc_ff    <= PW'(mag((MW+1)'(req_seg_bx) - (MW+1)'(req_seg_ax)));
                     mp_ff    <= LW'(mag((MW+1)'(req_seg_bx) - (MW+1)'(req_seg_ax)));
                     neg_ff   <= 1'b0;
                     acc_ff   <= '0;
                     cnt_ff   <= CNTW'(LW);
                     job_ff   <= JOB_LEN0;
                     state_ff <= ST_MUL;
                  end
               end
            end

            ST_MUL: begin
               if (mp_ff[0]) begin
                  acc_ff <= acc_ff + addend;
               end
               mc_ff  <= mc_ff << 1;
               mp_ff  <= mp_ff >> 1;
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNTW'(1)) begin
                  state_ff <= ST_POST;
               end
            end

            ST_DIV: begin
               if (rem_ge) begin
                  rem_ff <= rem_shift - len_ff;
               end else begin
                  rem_ff <= rem_shift;
               end
               t_ff   <= {t_ff[TW-2:0], rem_ge};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == CNTW'(1)) begin
                  mc_ff    <= PW'(mag(abx_ff));
                  mp_ff    <= LW'({t_ff[TW-2:0], rem_ge});
                  neg_ff   <= 1'b0;
                  acc_ff   <= '0;
                  cnt_ff   <= CNTW'(LW);
                  job_ff   <= JOB_SCX;
                  state_ff <= ST_MUL;
               end
            end

            ST_POST: begin
               cnt_ff   <= CNTW'(LW);
               state_ff <= ST_MUL;
               case (job_ff)
                  JOB_LEN0: begin
                     mc_ff  <= PW'(mag(aby_ff));
                     mp_ff  <= LW'(mag(aby_ff));
                     job_ff <= JOB_LEN1;
                  end
                  JOB_LEN1: begin
                     len_ff <= acc_ff[PW-1:0];
                     acc_ff <= '0;
                     if (acc_ff == '0) begin
                        // Zero-length segment: distance to the start point.
                        sx_ff  <= apx_ff;
                        sy_ff  <= apy_ff;
                        mc_ff  <= PW'(mag(apx_ff));
                        mp_ff  <= LW'(mag(apx_ff));
                        job_ff <= JOB_DST0;
                     end else begin
                        mc_ff  <= PW'(mag(apx_ff));
                        mp_ff  <= LW'(mag(abx_ff));
                        neg_ff <= apx_ff[MW] ^ abx_ff[MW];
                        job_ff <= JOB_DOT0;
                     end
                  end
                  JOB_DOT0: begin
                     mc_ff  <= PW'(mag(apy_ff));
                     mp_ff  <= LW'(mag(aby_ff));
                     neg_ff <= apy_ff[MW] ^ aby_ff[MW];
                     job_ff <= JOB_DOT1;
                  end
                  JOB_DOT1: begin
                     neg_ff <= 1'b0;
                     acc_ff <= '0;
                     if (acc_ff[PW] || (acc_ff == '0)) begin
                        // Projection clamps to the start point.
                        sx_ff  <= apx_ff;
                        sy_ff  <= apy_ff;
                        mc_ff  <= PW'(mag(apx_ff));
                        mp_ff  <= LW'(mag(apx_ff));
                        job_ff <= JOB_DST0;
                     end else if (acc_ff[PW-1:0] >= len_ff) begin
                        // Projection clamps to the end point; the y job reuses t.
                        t_ff   <= TW'(1) << F;
                        mc_ff  <= PW'(mag(abx_ff));
                        mp_ff  <= LW'(TW'(1) << F);
                        job_ff <= JOB_SCX;
                     end else begin
                        rem_ff   <= acc_ff[PW-1:0];
                        t_ff     <= '0;
                        cnt_ff   <= CNTW'(F);
                        state_ff <= ST_DIV;
                     end
                  end
                  JOB_SCX: begin
                     sx_ff  <= offset_in;
                     acc_ff <= '0;
                     mc_ff  <= PW'(mag(aby_ff));
                     mp_ff  <= LW'(t_ff);
                     job_ff <= JOB_SCY;
                  end
                  JOB_SCY: begin
                     sy_ff  <= offset_in;
                     acc_ff <= '0;
                     mc_ff  <= PW'(mag(sx_ff));
                     mp_ff  <= LW'(mag(sx_ff));
                     job_ff <= JOB_DST0;
                  end
                  JOB_DST0: begin
                     mc_ff  <= PW'(mag(sy_ff));
                     mp_ff  <= LW'(mag(sy_ff));
                     job_ff <= JOB_DST1;
                  end
                  JOB_DST1: begin
                     // An equal distance keeps the earlier link.
                     if (d2_ext < best_ext) begin
                        best_dist_ff <= acc_ff[63:0];
                        best_id_ff   <= id_ff;
                     end
                     state_ff <= last_ff ? ST_OUT : ST_IDLE;
                  end
                  default: ;
               endcase
            end

            ST_OUT: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_id_ff     <= visible_ff ? best_id_ff : 32'd0;
                  scan_start_ff <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end

            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== hdl/nearest_segment_pick_checker.sv =====
// ----------------------------------------------------------------------------
// nearest_segment_pick_checker
// Port-level checks of the nearest segment pick unit.
// ----------------------------------------------------------------------------
module nearest_segment_pick_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_link,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_best_link_id
);

   // A result waits until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_best_link_id))
      else $error("result changed while stalled");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // An item that does not end a scan cannot raise a result right away.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_last_link |=> !$rose(rsp_valid))
      else $error("result raised by an item without the last mark");

endmodule

bind nearest_segment_pick_unit nearest_segment_pick_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_last_link    (req_last_link),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_best_link_id (rsp_best_link_id)
);
